### rtl/reprojection_static_point_scorer_defines.svh
// Assertion macros shared by the static point scorer RTL.
`ifndef REPROJECTION_STATIC_POINT_SCORER_DEFINES_SVH
`define REPROJECTION_STATIC_POINT_SCORER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define RSPS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rsps check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define RSPS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rsps check failed");

`endif

### rtl/rsps_pkg.sv
// Types, constants and the divider step of the static point scorer.
package rsps_pkg;

	localparam int POINTS_DEF = 1024;
	localparam int IDX_W      = 10;
	localparam int CRD_W      = 32;
	localparam int FOC_W      = 24;
	localparam int SCR_W      = 12;
	localparam int LIM_W      = 10;
	localparam int POSE_N     = 12;
	localparam int CFG_IDX_W  = 3;
	// Signed width of focal * coordinate, and the width of its magnitude.
	localparam int NUM_W      = 57;
	localparam int QW         = 56;
	localparam int LANES      = 4;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_DIST_LIMIT  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SCORE_LIMIT = 3'd5;

	// Item kinds.
	localparam logic ACT_POSE  = 1'b0;
	localparam logic ACT_POINT = 1'b1;

	// Reset values.
	localparam logic [FOC_W-1:0] FOCAL_RST = 24'd134400;
	localparam logic [FOC_W-1:0] DIST_RST  = 24'd1280;
	localparam logic [LIM_W-1:0] SLIM_RST  = 10'd4;
	localparam logic signed [CRD_W-1:0] POSE_ONE = 32'sh0100_0000;

	// Side information that travels with a point through the pipeline.
	typedef struct packed {
		logic             vld;
		logic             inr;
		logic             match;
		logic             zero;
		logic [IDX_W-1:0] idx;
	} ctl_t;

	// One restoring-division lane: partial remainder and dividend/quotient word.
	typedef struct packed {
		logic [31:0]   rem;
		logic [QW-1:0] w;
	} dlane_t;

	// One stage of the division pipeline.
	typedef struct packed {
		ctl_t                   ctl;
		dlane_t [LANES-1:0]     lane;
		logic   [LANES-1:0]     neg;
		logic   [31:0]          dp;
		logic   [31:0]          dm;
	} dstage_t;

	// One quotient bit of an unsigned restoring division.
	function automatic dlane_t div_step(dlane_t l, logic [31:0] d);
		logic [32:0] t;
		logic [32:0] df;
		dlane_t      r;
		t  = {l.rem, l.w[QW-1]};
		df = t - {1'b0, d};
		if (!df[32]) begin
			r.rem = df[31:0];
			r.w   = {l.w[QW-2:0], 1'b1};
		end else begin
			r.rem = t[31:0];
			r.w   = {l.w[QW-2:0], 1'b0};
		end
		return r;
	endfunction

endpackage

### rtl/reprojection_static_point_scorer.sv
// Throughput: one item per cycle unless the output stalls; the fully pipelined divider has
// 56 quotient-bit stages; the score memory's read-modify-write forwards the last write-back.
// Reset clears configuration to defaults and the pose to identity, then a clearing
// pass writes every score entry, with in_ready held low until it ends.
// Pose-load items give no result; an output stall holds the whole pipeline.
`include "reprojection_static_point_scorer_defines.svh"

module reprojection_static_point_scorer #(
	parameter int MAX_POINTS = rsps_pkg::POINTS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rsps_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [rsps_pkg::FOC_W-1:0]            cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  action,
	input  logic [3:0]                            pose_slot,
	input  logic signed [rsps_pkg::CRD_W-1:0]     pose_value,
	input  logic [rsps_pkg::IDX_W-1:0]            point_index,
	input  logic                                  has_match,
	input  logic signed [rsps_pkg::CRD_W-1:0]     prev_x,
	input  logic signed [rsps_pkg::CRD_W-1:0]     prev_y,
	input  logic signed [rsps_pkg::CRD_W-1:0]     prev_z,
	input  logic signed [rsps_pkg::CRD_W-1:0]     curr_x,
	input  logic signed [rsps_pkg::CRD_W-1:0]     curr_y,
	input  logic signed [rsps_pkg::CRD_W-1:0]     curr_z,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic [rsps_pkg::IDX_W-1:0]            result_index,
	output logic                                  is_static,
	output logic signed [rsps_pkg::SCR_W-1:0]     point_score,
	output logic                                  has_score
);
	import rsps_pkg::*;

	localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int MEM_W = SCR_W + 1;

	// Configuration registers. The principal point cancels in the pixel
	// difference, so center writes are taken and need no storage.
	logic [FOC_W-1:0] fx_q, fy_q, dl_q;
	logic [LIM_W-1:0] slim_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fx_q   <= FOCAL_RST;
			fy_q   <= FOCAL_RST;
			dl_q   <= DIST_RST;
			slim_q <= SLIM_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_FOCAL_X:     fx_q   <= cfg_data;
				CFG_FOCAL_Y:     fy_q   <= cfg_data;
				CFG_CENTER_X:    ;
				CFG_CENTER_Y:    ;
				CFG_DIST_LIMIT:  dl_q   <= cfg_data;
				CFG_SCORE_LIMIT: slim_q <= cfg_data[LIM_W-1:0];
				default:         ;
			endcase
		end
	end

	// Handshake and pipeline advance.
	logic adv, acc, clr_q, out_valid_q;
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv && !clr_q;
	assign acc      = in_valid && in_ready;

	// Pose coefficients, written when a pose-load item with a slot below POSE_N is accepted.
	logic signed [CRD_W-1:0] pose_q [POSE_N];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < POSE_N; i++) begin
				pose_q[i] <= (i % 5 == 0 && i < 11) ? POSE_ONE : '0;
			end
		end else if (acc && action == ACT_POSE && pose_slot < 4'(POSE_N)) begin
			pose_q[pose_slot] <= pose_value;
		end
	end

	// Stage 1: register the point.
	ctl_t                    ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic signed [CRD_W-1:0] prev_s1 [3];
	logic signed [CRD_W-1:0] curr_s1 [3];
	ctl_t                    ctl_in;

	always_comb begin
		ctl_in.vld   = acc && action == ACT_POINT;
		ctl_in.inr   = 32'(point_index) < 32'(MAX_POINTS);
		ctl_in.match = has_match;
		ctl_in.zero  = 1'b0;
		ctl_in.idx   = point_index;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			prev_s1[0] <= prev_x;
			prev_s1[1] <= prev_y;
			prev_s1[2] <= prev_z;
			curr_s1[0] <= curr_x;
			curr_s1[1] <= curr_y;
			curr_s1[2] <= curr_z;
		end
	end

	// Stage 2: rotation products and scaled translation.
	logic signed [63:0]      prod_s2 [3][3];
	logic signed [23:0]      tsh_s2  [3];
	logic signed [CRD_W-1:0] prev_s2 [3];

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s2[i][j] <= 64'(pose_q[i*4+j]) * 64'(curr_s1[j]);
				end
				tsh_s2[i]  <= pose_q[i*4+3][31:8];
				prev_s2[i] <= prev_s1[i];
			end
		end
	end

	// Stage 3: row sums, saturated to 32 bits.
	logic signed [CRD_W-1:0] moved_s3 [3];
	logic signed [CRD_W-1:0] prev_s3  [3];
	logic signed [CRD_W-1:0] moved_nx [3];

	always_comb begin
		logic signed [41:0] sum;
		for (int i = 0; i < 3; i++) begin
			sum = 42'($signed(prod_s2[i][0][63:24])) + 42'($signed(prod_s2[i][1][63:24]))
				+ 42'($signed(prod_s2[i][2][63:24])) + 42'(tsh_s2[i]);
			if (sum > 42'sd2147483647) begin
				moved_nx[i] = 32'sh7FFF_FFFF;
			end else if (sum < -42'sd2147483648) begin
				moved_nx[i] = 32'sh8000_0000;
			end else begin
				moved_nx[i] = sum[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int i = 0; i < 3; i++) begin
				moved_s3[i] <= moved_nx[i];
				prev_s3[i]  <= prev_s2[i];
			end
		end
	end

	// Stage 4: projection numerators focal * coordinate.
	logic signed [NUM_W-1:0] num_s4 [LANES];
	logic signed [CRD_W-1:0] zp_s4, zm_s4;

	always_ff @(posedge clk) begin
		if (adv) begin
			num_s4[0] <= 57'($signed({1'b0, fx_q})) * 57'(prev_s3[0]);
			num_s4[1] <= 57'($signed({1'b0, fy_q})) * 57'(prev_s3[1]);
			num_s4[2] <= 57'($signed({1'b0, fx_q})) * 57'(moved_s3[0]);
			num_s4[3] <= 57'($signed({1'b0, fy_q})) * 57'(moved_s3[1]);
			zp_s4     <= prev_s3[2];
			zm_s4     <= moved_s3[2];
		end
	end

	// Stage 3 control with the zero-depth flag filled in.
	ctl_t ctl_s3z;

	always_comb begin
		ctl_s3z      = ctl_s3;
		ctl_s3z.zero = prev_s3[2] == '0 || moved_s3[2] == '0;
	end

	// Control for stages 2 to 4; stage 4 notes a zero depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (adv) begin
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3z;
		end
	end

	// Divider entry: magnitudes and quotient signs.
	dstage_t div_q  [QW+1];
	dstage_t div_nx [QW+1];

	always_comb begin
		logic signed [NUM_W-1:0] mag;
		logic signed [32:0]      zpe, zme;
		zpe = 33'(zp_s4);
		zme = 33'(zm_s4);
		div_nx[0].ctl = ctl_s4;
		div_nx[0].dp  = zpe[32] ? 32'(-zpe) : zpe[31:0];
		div_nx[0].dm  = zme[32] ? 32'(-zme) : zme[31:0];
		for (int k = 0; k < LANES; k++) begin
			mag                   = num_s4[k][NUM_W-1] ? -num_s4[k] : num_s4[k];
			div_nx[0].lane[k].rem = '0;
			div_nx[0].lane[k].w   = mag[QW-1:0];
			div_nx[0].neg[k]      = num_s4[k][NUM_W-1] ^ ((k < 2) ? zp_s4[CRD_W-1]
				: zm_s4[CRD_W-1]);
		end
		for (int s = 1; s <= QW; s++) begin
			div_nx[s]     = div_q[s-1];
			div_nx[s].lane[0] = div_step(div_q[s-1].lane[0], div_q[s-1].dp);
			div_nx[s].lane[1] = div_step(div_q[s-1].lane[1], div_q[s-1].dp);
			div_nx[s].lane[2] = div_step(div_q[s-1].lane[2], div_q[s-1].dm);
			div_nx[s].lane[3] = div_step(div_q[s-1].lane[3], div_q[s-1].dm);
		end
	end

	// Division pipeline: one quotient bit per stage after the entry stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 0; s <= QW; s++) begin
				div_q[s].ctl <= '0;
			end
		end else if (adv) begin
			for (int s = 0; s <= QW; s++) begin
				div_q[s] <= div_nx[s];
			end
		end
	end

	// Stage 5: signed quotients, rounded toward zero.
	ctl_t                    ctl_s5, ctl_s6, ctl_s7, ctl_s8, ctl_s9;
	logic signed [NUM_W-1:0] quot_s5 [LANES];
	logic signed [NUM_W-1:0] quot_nx [LANES];

	always_comb begin
		logic [NUM_W-1:0] uq;
		for (int k = 0; k < LANES; k++) begin
			uq         = {1'b0, div_q[QW].lane[k].w};
			quot_nx[k] = div_q[QW].neg[k] ? -$signed(uq) : $signed(uq);
		end
	end

	// Stage 6: pixel differences; the principal point cancels.
	logic signed [NUM_W:0] dx_s6, dy_s6;
	// Stage 7: range check and narrowing.
	logic                  ok_s7, ok_s8;
	logic signed [25:0]    dxt_s7, dyt_s7;
	// Stage 8: squares.
	logic [51:0]           dx2_s8, dy2_s8;
	logic [47:0]           l2_s8;
	// Stage 9: consistency flag.
	logic                  cons_s9;

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < LANES; k++) begin
				quot_s5[k] <= quot_nx[k];
			end
			dx_s6   <= 58'(quot_s5[0]) - 58'(quot_s5[2]);
			dy_s6   <= 58'(quot_s5[1]) - 58'(quot_s5[3]);
			ok_s7   <= dx_s6 <= 58'sd16777216 && dx_s6 >= -58'sd16777216
				&& dy_s6 <= 58'sd16777216 && dy_s6 >= -58'sd16777216;
			dxt_s7  <= dx_s6[25:0];
			dyt_s7  <= dy_s6[25:0];
			ok_s8   <= ok_s7;
			dx2_s8  <= 52'(52'(dxt_s7) * 52'(dxt_s7));
			dy2_s8  <= 52'(52'(dyt_s7) * 52'(dyt_s7));
			l2_s8   <= 48'(dl_q) * 48'(dl_q);
			cons_s9 <= ok_s8 && !ctl_s8.zero
				&& ({1'b0, dx2_s8} + {1'b0, dy2_s8}) < {5'b0, l2_s8};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s5 <= '0;
			ctl_s6 <= '0;
			ctl_s7 <= '0;
			ctl_s8 <= '0;
			ctl_s9 <= '0;
		end else if (adv) begin
			ctl_s5 <= div_q[QW].ctl;
			ctl_s6 <= ctl_s5;
			ctl_s7 <= ctl_s6;
			ctl_s8 <= ctl_s7;
			ctl_s9 <= ctl_s8;
		end
	end

	// Score memory addresses.
	logic [AW+IDX_W-1:0] ext_s8, ext_s9;
	logic [AW-1:0]       a_s8, a_s9, rd_addr, wr_addr, clr_cnt_q;
	assign ext_s8  = {{AW{1'b0}}, ctl_s8.idx};
	assign ext_s9  = {{AW{1'b0}}, ctl_s9.idx};
	assign a_s8    = ext_s8[AW-1:0];
	assign a_s9    = ext_s9[AW-1:0];
	assign rd_addr = adv ? a_s8 : a_s9;

	// Score memory: {mark, score} per point, read-first, with a registered read.
	logic [MEM_W-1:0] mem [MAX_POINTS];
	logic [MEM_W-1:0] rd_q, wr_data, cur;
	logic             we, rmw_we;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[wr_addr] <= wr_data;
		end
		rd_q <= mem[rd_addr];
	end

	// Last write-back, forwarded to the entry now under update.
	logic             lw_valid_q;
	logic [AW-1:0]    lw_addr_q;
	logic [MEM_W-1:0] lw_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lw_valid_q <= 1'b0;
		end else if (rmw_we) begin
			lw_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rmw_we) begin
			lw_addr_q <= a_s9;
			lw_data_q <= wr_data;
		end
	end

	assign cur = (lw_valid_q && lw_addr_q == a_s9) ? lw_data_q : rd_q;

	// Score update: one step up or down within twice the score limit.
	logic signed [SCR_W-1:0] maxs, old_sc, new_sc, res_sc;
	logic                    res_mark;

	always_comb begin
		maxs   = $signed({1'b0, slim_q, 1'b0});
		old_sc = $signed(cur[SCR_W-1:0]);
		if (cons_s9 && old_sc < maxs) begin
			new_sc = old_sc + 12'sd1;
		end else if (old_sc > -maxs) begin
			new_sc = old_sc - 12'sd1;
		end else begin
			new_sc = old_sc;
		end
		if (!ctl_s9.inr) begin
			res_sc   = '0;
			res_mark = 1'b0;
		end else if (ctl_s9.match) begin
			res_sc   = new_sc;
			res_mark = 1'b1;
		end else begin
			res_sc   = old_sc;
			res_mark = cur[SCR_W];
		end
	end

	// Clearing pass after reset, then write-back of updated scores.
	assign rmw_we  = adv && ctl_s9.vld && ctl_s9.inr && ctl_s9.match;
	assign we      = clr_q || rmw_we;
	assign wr_addr = clr_q ? clr_cnt_q : a_s9;
	assign wr_data = clr_q ? '0 : {1'b1, new_sc};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + 1'b1;
			if (clr_cnt_q == AW'(MAX_POINTS - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Output register.
	logic [IDX_W-1:0]        oidx_q;
	logic signed [SCR_W-1:0] osc_q;
	logic                    omark_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl_s9.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			oidx_q  <= ctl_s9.idx;
			osc_q   <= res_sc;
			omark_q <= res_mark;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_index = oidx_q;
	assign point_score  = osc_q;
	assign has_score    = omark_q;
	assign is_static    = omark_q && osc_q > 12'sd0;

	// Checks on the clearing pass, the write-back path and the score bounds.
	`RSPS_ASSERT_IMP(a_clear_blocks_input, clr_q, !in_ready)
	`RSPS_ASSERT_IMP(a_clear_excl_update, clr_q, !rmw_we)
	`RSPS_ASSERT_NXT(a_fwd_tracks_write, rmw_we, lw_valid_q && lw_addr_q == $past(a_s9))
	`RSPS_ASSERT_IMP(a_unscored_zero, out_valid && !has_score, point_score == 12'sd0)
	`RSPS_ASSERT_IMP(a_score_bounded, out_valid,
		point_score <= 12'sd2046 && point_score >= -12'sd2046)

endmodule
